// ===== sv/dlr_pkg.sv =====
// dlr_pkg: shared constants, action codes and controller/datapath interface structs
// for the dda line rasterizer; no dependencies
package dlr_pkg;

  // default geometry
  localparam int COORD_BITS_DEF    = 10;
  localparam int FRACTION_BITS_DEF = 16;

  // action codes of an input beat
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_start;  // latch endpoints and form deltas
    logic setup;       // form magnitudes, step count and divider seed
    logic div_step;    // one shift-subtract iteration on both axes
    logic advance;     // emit current pixel and move to the next
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_len;    // both deltas are zero
    logic last;        // one pixel left on the line
  } sts_t;

endpackage

// ===== sv/dlr_ctrl.sv =====
// dlr_ctrl: sequencing state machine and output valid tracking for the
// dda line rasterizer; depends on dlr_pkg
module dlr_ctrl #(
  parameter int FRACTION_BITS = dlr_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output dlr_pkg::cmd_t cmd,
  input  dlr_pkg::sts_t sts
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_ACTIVE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             accept;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  // ready: any beat is taken when idle; while active, start beats always, step beats need the slot
  always_comb begin
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_ACTIVE: in_ready = (in_action == dlr_pkg::ACT_START) ? 1'b1 : out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action == dlr_pkg::ACT_START) begin
          cmd.load_start = 1'b1;
          state_nxt      = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.zero_len ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRACTION_BITS)) begin
          state_nxt = ST_ACTIVE;
        end
      end
      ST_ACTIVE: begin
        if (accept) begin
          if (in_action == dlr_pkg::ACT_START) begin
            cmd.load_start = 1'b1;
            state_nxt      = ST_SETUP;
          end else begin
            cmd.advance = 1'b1;
            if (sts.last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on emit, cleared when taken
  always_comb begin
    if (cmd.advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/dlr_dp.sv =====
// dlr_dp: deltas, radix-2 shift-subtract increment divider, position
// accumulators and output pixel registers; depends on dlr_pkg
module dlr_dp #(
  parameter int COORD_BITS    = dlr_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = dlr_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel,
  input  dlr_pkg::cmd_t         cmd,
  output dlr_pkg::sts_t         sts
);

  localparam int CW = COORD_BITS;
  localparam int FW = FRACTION_BITS;
  localparam int PW = CW + FW;
  localparam int QW = FW + 1;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FW - 1);

  logic [CW-1:0] xs_r, ys_r;
  logic [CW:0]   dx_r, dy_r;
  logic          neg_x_r, neg_y_r;
  logic [CW-1:0] steps_r;
  logic [CW:0]   rem_x_r, rem_y_r;
  logic [QW-1:0] q_x_r, q_y_r;
  logic [PW-1:0] pos_x_r, pos_y_r;
  logic [CW:0]   left_r;
  logic [CW-1:0] pix_x_r, pix_y_r;
  logic          last_r;

  logic [CW:0]   adx_full, ady_full;
  logic [CW-1:0] adx, ady, steps_nxt;
  logic          ge_x, ge_y;
  logic [CW:0]   sub_x, sub_y;
  logic [PW-1:0] pos_x_nxt, pos_y_nxt;
  logic [PW:0]   rnd_x, rnd_y;

  // magnitudes and step count from the latched deltas
  assign adx_full  = dx_r[CW] ? (~dx_r + (CW + 1)'(1)) : dx_r;
  assign ady_full  = dy_r[CW] ? (~dy_r + (CW + 1)'(1)) : dy_r;
  assign adx       = adx_full[CW-1:0];
  assign ady       = ady_full[CW-1:0];
  assign steps_nxt = (adx >= ady) ? adx : ady;

  // divider trial subtraction, one quotient bit per cycle
  assign ge_x  = rem_x_r >= {1'b0, steps_r};
  assign ge_y  = rem_y_r >= {1'b0, steps_r};
  assign sub_x = ge_x ? (rem_x_r - {1'b0, steps_r}) : rem_x_r;
  assign sub_y = ge_y ? (rem_y_r - {1'b0, steps_r}) : rem_y_r;

  // position update by signed increment
  assign pos_x_nxt = neg_x_r ? (pos_x_r - PW'(q_x_r)) : (pos_x_r + PW'(q_x_r));
  assign pos_y_nxt = neg_y_r ? (pos_y_r - PW'(q_y_r)) : (pos_y_r + PW'(q_y_r));

  // round half up
  assign rnd_x = {1'b0, pos_x_r} + HALF;
  assign rnd_y = {1'b0, pos_y_r} + HALF;

  assign sts.zero_len = (dx_r == '0) && (dy_r == '0);
  assign sts.last     = left_r == (CW + 1)'(1);

  always_ff @(posedge clk) begin
    // latch endpoints
    if (cmd.load_start) begin
      xs_r <= in_x_start;
      ys_r <= in_y_start;
      dx_r <= {1'b0, in_x_end} - {1'b0, in_x_start};
      dy_r <= {1'b0, in_y_end} - {1'b0, in_y_start};
    end
    // seed divider and accumulators
    if (cmd.setup) begin
      neg_x_r <= dx_r[CW];
      neg_y_r <= dy_r[CW];
      steps_r <= steps_nxt;
      rem_x_r <= {1'b0, adx};
      rem_y_r <= {1'b0, ady};
      pos_x_r <= {xs_r, FW'(0)};
      pos_y_r <= {ys_r, FW'(0)};
      left_r  <= {1'b0, steps_nxt} + (CW + 1)'(1);
    end
    // shift-subtract iteration
    if (cmd.div_step) begin
      rem_x_r <= {sub_x[CW-1:0], 1'b0};
      rem_y_r <= {sub_y[CW-1:0], 1'b0};
      q_x_r   <= {q_x_r[QW-2:0], ge_x};
      q_y_r   <= {q_y_r[QW-2:0], ge_y};
    end
    // emit pixel and step along the line
    if (cmd.advance) begin
      pix_x_r <= rnd_x[FW +: CW];
      pix_y_r <= rnd_y[FW +: CW];
      last_r  <= sts.last;
      left_r  <= left_r - (CW + 1)'(1);
      if (!sts.last) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  assign out_pixel_x    = pix_x_r;
  assign out_pixel_y    = pix_y_r;
  assign out_last_pixel = last_r;

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// dda_line_rasterizer: a start beat runs setup and radix-2 shift-subtract division of
// both increments before new beats are taken
// a zero-length start skips the divider and the input is free again after setup
// step beats: one pixel per cycle while the output slot is free, registered on acceptance
// rate is set by the single output register and the one-bit-per-cycle divider
// reset: synchronous active-low rst_n clears the controller and output valid, no line active
module dda_line_rasterizer #(
  parameter int COORD_BITS    = dlr_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = dlr_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel
);

  dlr_pkg::cmd_t cmd;
  dlr_pkg::sts_t sts;

  // sequencing
  dlr_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // arithmetic
  dlr_dp #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel),
    .cmd           (cmd),
    .sts           (sts)
  );

  // no beat is taken while the divider runs
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.setup) |-> !in_ready)
    else $error("input ready while dividing");

  // a pixel is only emitted into a free output slot
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (!out_valid || out_ready))
    else $error("pixel emitted over a pending beat");

  // a start is always followed by setup
  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_start |=> cmd.setup)
    else $error("start not followed by setup");

  // an emitted pixel shows up as a valid beat
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> out_valid)
    else $error("emitted pixel not presented");

endmodule
